@@ hdl/skb_pkg.sv @@
// Package for the SSH public key blob parser.
// Holds the parse phase, key type and error code types and the type name tables.
// No dependencies; the parser and its testbench use it.
`default_nettype none

package skb_pkg;

    typedef enum logic [6:0] {
        PH_TYPE_LEN  = 7'b0000001,
        PH_TYPE_DATA = 7'b0000010,
        PH_A_LEN     = 7'b0000100,
        PH_A_DATA    = 7'b0001000,
        PH_B_LEN     = 7'b0010000,
        PH_B_DATA    = 7'b0100000,
        PH_DONE      = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        KT_UNKNOWN = 2'd0,
        KT_RSA     = 2'd1,
        KT_ED      = 2'd2
    } t_key;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_TRUNC    = 3'd1,
        ERR_TYPE     = 3'd2,
        ERR_FORM     = 3'd3,
        ERR_RANGE    = 3'd4,
        ERR_TRAILING = 3'd5
    } t_err;

    localparam logic [3:0]  RSA_NAME_LEN  = 4'd7;
    localparam logic [3:0]  ED_NAME_LEN   = 4'd11;
    localparam logic [31:0] ED_KEY_LEN    = 32'd32;
    localparam logic [3:0]  MIN_BLOB_LEN  = 4'd8;
    localparam logic [15:0] MAX_MPINT_RST = 16'd1024;

    function automatic logic [7:0] rsa_name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h73;
            4'd1:    c = 8'h73;
            4'd2:    c = 8'h68;
            4'd3:    c = 8'h2d;
            4'd4:    c = 8'h72;
            4'd5:    c = 8'h73;
            4'd6:    c = 8'h61;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ed_name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h73;
            4'd1:    c = 8'h73;
            4'd2:    c = 8'h68;
            4'd3:    c = 8'h2d;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h64;
            4'd6:    c = 8'h32;
            4'd7:    c = 8'h35;
            4'd8:    c = 8'h35;
            4'd9:    c = 8'h31;
            4'd10:   c = 8'h39;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/skb_if.sv @@
// Channel interfaces of the SSH public key blob parser: blob bytes in,
// verdicts out and the configuration write channel. No dependencies.
`default_nettype none

interface skb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface skb_res_if;
    logic       valid;
    logic       ready;
    logic       valid_res;
    logic [1:0] key_type;
    logic [2:0] error_code;

    modport source (output valid, output valid_res, output key_type, output error_code,
                    input ready);
    modport sink (input valid, input valid_res, input key_type, input error_code,
                  output ready);
endinterface

interface skb_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_mpint_bytes;

    modport source (output valid, output max_mpint_bytes, input ready);
    modport sink (input valid, input max_mpint_bytes, output ready);
endinterface

`default_nettype wire

@@ hdl/ssh_key_blob_parser.sv @@
// SSH public key blob parser: one byte per cycle, one verdict per blob.
// The verdict is loaded into the result register in the cycle after the last byte's transfer.
// Throughput is one byte per cycle, set by the phase and counter update made for each accepted byte.
// Input stalls only while a verdict waits in the result register and is not taken.
// Synchronous active-low reset clears the parse state, empties the result register
// and sets the maximum mpint length to 1024. Depends on skb_pkg and skb_if.
`default_nettype none

module ssh_key_blob_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    skb_cfg_if.sink     i_cfg,
    skb_byte_if.sink    i_blob,
    skb_res_if.source   o_res
);

    logic [15:0]     r_max;
    skb_pkg::t_phase r_phase, n_phase;
    logic [23:0]     r_flen, n_flen;
    logic [1:0]      r_lcnt, n_lcnt;
    logic [15:0]     r_left, n_left;
    logic [3:0]      r_idx, n_idx;
    logic [3:0]      r_total, n_total;
    logic [1:0]      r_flags, n_flags;
    logic            r_first_zero, n_first_zero;
    skb_pkg::t_key   r_found, n_found;
    skb_pkg::t_err   r_err, n_err;

    logic            r_out_valid;
    logic            r_res_ok;
    skb_pkg::t_key   r_res_key;
    skb_pkg::t_err   r_res_err;

    logic            accept;
    logic [7:0]      b;
    logic [31:0]     v_len;
    logic            v_mpint_bad;
    logic            v_stop;
    logic            v_rsa_hit;
    logic            v_ed_hit;
    skb_pkg::t_err   v_verdict;

    assign accept        = i_blob.valid && i_blob.ready;
    assign b             = i_blob.data_byte;
    assign i_blob.ready  = !r_out_valid || o_res.ready;
    assign i_cfg.ready   = 1'b1;

    assign v_len       = {r_flen, b};
    assign v_mpint_bad = (v_len == 32'd0) || (v_len > {16'd0, r_max});
    assign v_rsa_hit   = (r_idx < skb_pkg::RSA_NAME_LEN) && (skb_pkg::rsa_name_char(r_idx) == b);
    assign v_ed_hit    = (r_idx < skb_pkg::ED_NAME_LEN) && (skb_pkg::ed_name_char(r_idx) == b);

    always_comb begin
        n_phase      = r_phase;
        n_flen       = r_flen;
        n_lcnt       = r_lcnt;
        n_left       = r_left;
        n_idx        = r_idx;
        n_flags      = r_flags;
        n_first_zero = r_first_zero;
        n_found      = r_found;
        n_err        = r_err;
        n_total      = (r_total < skb_pkg::MIN_BLOB_LEN) ? r_total + 4'd1 : r_total;
        v_stop       = 1'b0;
        v_verdict    = skb_pkg::ERR_NONE;

        if (r_err == skb_pkg::ERR_NONE) begin
            case (r_phase)
                skb_pkg::PH_TYPE_LEN, skb_pkg::PH_A_LEN, skb_pkg::PH_B_LEN: begin
                    n_flen = v_len[23:0];
                    if (r_lcnt != 2'd3) begin
                        n_lcnt = r_lcnt + 2'd1;
                    end else begin
                        n_lcnt       = 2'd0;
                        n_left       = v_len[15:0];
                        n_idx        = 4'd0;
                        n_first_zero = 1'b0;
                        case (r_phase)
                            skb_pkg::PH_TYPE_LEN: begin
                                if (v_len == {28'd0, skb_pkg::RSA_NAME_LEN}) begin
                                    n_flags = 2'b01;
                                    n_found = skb_pkg::KT_RSA;
                                end else if (v_len == {28'd0, skb_pkg::ED_NAME_LEN}) begin
                                    n_flags = 2'b10;
                                    n_found = skb_pkg::KT_ED;
                                end else begin
                                    n_flags = 2'b00;
                                    n_err   = skb_pkg::ERR_TYPE;
                                end
                                n_phase = skb_pkg::PH_TYPE_DATA;
                            end
                            skb_pkg::PH_A_LEN: begin
                                if (r_found == skb_pkg::KT_RSA) begin
                                    if (v_mpint_bad) begin
                                        n_err = skb_pkg::ERR_RANGE;
                                    end
                                end else if (v_len != skb_pkg::ED_KEY_LEN) begin
                                    n_err = skb_pkg::ERR_RANGE;
                                end
                                n_phase = skb_pkg::PH_A_DATA;
                            end
                            default: begin
                                if (v_mpint_bad) begin
                                    n_err = skb_pkg::ERR_RANGE;
                                end
                                n_phase = skb_pkg::PH_B_DATA;
                            end
                        endcase
                    end
                end
                skb_pkg::PH_TYPE_DATA, skb_pkg::PH_A_DATA, skb_pkg::PH_B_DATA: begin
                    if (r_phase == skb_pkg::PH_TYPE_DATA) begin
                        n_flags = {r_flags[1] && v_ed_hit, r_flags[0] && v_rsa_hit};
                        if (n_flags == 2'b00) begin
                            n_err  = skb_pkg::ERR_TYPE;
                            v_stop = 1'b1;
                        end
                    end else if (r_found == skb_pkg::KT_RSA) begin
                        if (r_idx == 4'd0) begin
                            if (b[7]) begin
                                n_err  = skb_pkg::ERR_FORM;
                                v_stop = 1'b1;
                            end else begin
                                n_first_zero = (b == 8'd0);
                            end
                        end else if (r_idx == 4'd1) begin
                            if (r_first_zero && !b[7]) begin
                                n_err  = skb_pkg::ERR_FORM;
                                v_stop = 1'b1;
                            end
                        end
                    end
                    if (!v_stop) begin
                        n_left = r_left - 16'd1;
                        n_idx  = (r_idx == 4'hF) ? r_idx : r_idx + 4'd1;
                        if (r_left == 16'd1) begin
                            case (r_phase)
                                skb_pkg::PH_TYPE_DATA: n_phase = skb_pkg::PH_A_LEN;
                                skb_pkg::PH_A_DATA: begin
                                    n_phase = (r_found == skb_pkg::KT_RSA) ?
                                              skb_pkg::PH_B_LEN : skb_pkg::PH_DONE;
                                end
                                default: n_phase = skb_pkg::PH_DONE;
                            endcase
                        end
                    end
                end
                skb_pkg::PH_DONE: begin
                    n_err = skb_pkg::ERR_TRAILING;
                end
                default: begin
                    n_err = r_err;
                end
            endcase
        end

        if (n_total < skb_pkg::MIN_BLOB_LEN) begin
            v_verdict = skb_pkg::ERR_TRUNC;
        end else if (n_err != skb_pkg::ERR_NONE) begin
            v_verdict = n_err;
        end else if (n_phase != skb_pkg::PH_DONE) begin
            v_verdict = skb_pkg::ERR_TRUNC;
        end else begin
            v_verdict = skb_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= skb_pkg::MAX_MPINT_RST;
            r_phase      <= skb_pkg::PH_TYPE_LEN;
            r_flen       <= '0;
            r_lcnt       <= '0;
            r_left       <= '0;
            r_idx        <= '0;
            r_total      <= '0;
            r_flags      <= 2'b11;
            r_first_zero <= 1'b0;
            r_found      <= skb_pkg::KT_UNKNOWN;
            r_err        <= skb_pkg::ERR_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_max <= i_cfg.max_mpint_bytes;
            end
            if (accept && i_blob.last_byte) begin
                r_phase      <= skb_pkg::PH_TYPE_LEN;
                r_flen       <= '0;
                r_lcnt       <= '0;
                r_left       <= '0;
                r_idx        <= '0;
                r_total      <= '0;
                r_flags      <= 2'b11;
                r_first_zero <= 1'b0;
                r_found      <= skb_pkg::KT_UNKNOWN;
                r_err        <= skb_pkg::ERR_NONE;
            end else if (accept) begin
                r_phase      <= n_phase;
                r_flen       <= n_flen;
                r_lcnt       <= n_lcnt;
                r_left       <= n_left;
                r_idx        <= n_idx;
                r_total      <= n_total;
                r_flags      <= n_flags;
                r_first_zero <= n_first_zero;
                r_found      <= n_found;
                r_err        <= n_err;
            end
            if (accept && i_blob.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_blob.last_byte) begin
            r_res_ok  <= (v_verdict == skb_pkg::ERR_NONE);
            r_res_key <= (v_verdict == skb_pkg::ERR_NONE) ? n_found : skb_pkg::KT_UNKNOWN;
            r_res_err <= v_verdict;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.valid_res  = r_res_ok;
    assign o_res.key_type   = r_res_key;
    assign o_res.error_code = r_res_err;

    a_ok_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.valid_res == (o_res.error_code == skb_pkg::ERR_NONE)))
        else $error("verdict flag disagrees with error code");

    a_failed_has_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.valid_res) |-> (o_res.key_type == skb_pkg::KT_UNKNOWN))
        else $error("rejected blob reports a key type");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_blob.last_byte) |=> o_res.valid)
        else $error("last byte transfer did not load a verdict");

    a_total_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= skb_pkg::MIN_BLOB_LEN)
        else $error("byte count passed its saturation value");

    a_type_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != skb_pkg::PH_TYPE_LEN) |-> $onehot0(r_flags))
        else $error("both key types still match after the type length");

endmodule

`default_nettype wire

@@ tb/sv/tb_ssh_key_blob_parser.sv @@
// Testbench for ssh_key_blob_parser: directed and random SSH key blobs, with verdicts
// checked against a cycle-free predictor held in a small scoreboard class.
// Depends on skb_pkg, the skb_if channel interfaces and the parser RTL.
`timescale 1ns / 1ps

module tb_ssh_key_blob_parser;

    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned SETTLE      = 4;
    localparam int unsigned PHASE_BYTES = 210;

    class blob_verdict_sb;

        typedef struct packed {
            logic          ok;
            skb_pkg::t_key kind;
            skb_pkg::t_err err;
        } verdict_t;

        verdict_t    expected_q[$];
        int unsigned mismatches;
        int unsigned noted;
        int unsigned checked;
        int unsigned code_count[8];
        int unsigned rsa_ok;
        int unsigned ed_ok;
        logic [15:0] max_len;

        skb_pkg::t_phase stage;
        logic [31:0]     flen;
        logic [31:0]     left;
        logic [3:0]      seen;
        logic [1:0]      flags;
        logic            first_zero;
        skb_pkg::t_key   kind;
        skb_pkg::t_err   err;
        string           rsa_txt = "ssh-rsa";
        string           ed_txt  = "ssh-ed25519";

        function new();
            max_len = skb_pkg::MAX_MPINT_RST;
            restart();
        endfunction

        function void restart();
            stage      = skb_pkg::PH_TYPE_LEN;
            flen       = '0;
            left       = '0;
            seen       = '0;
            flags      = 2'b11;
            first_zero = 1'b0;
            kind       = skb_pkg::KT_UNKNOWN;
            err        = skb_pkg::ERR_NONE;
        endfunction

        function void set_max(logic [15:0] v);
            max_len = v;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void check_mpint_len(logic [31:0] n);
            if (n == 0 || n > {16'd0, max_len}) begin
                err = skb_pkg::ERR_RANGE;
            end
        endfunction

        function void length_byte(logic [7:0] b);
            logic [31:0] n;
            flen = {flen[23:0], b};
            left = left + 1;
            if (left < 4) begin
                return;
            end
            n    = flen;
            left = n;
            case (stage)
                skb_pkg::PH_TYPE_LEN: begin
                    if (n == 32'(skb_pkg::RSA_NAME_LEN)) begin
                        flags = 2'b01;
                        kind  = skb_pkg::KT_RSA;
                    end else if (n == 32'(skb_pkg::ED_NAME_LEN)) begin
                        flags = 2'b10;
                        kind  = skb_pkg::KT_ED;
                    end else begin
                        flags = 2'b00;
                        err   = skb_pkg::ERR_TYPE;
                    end
                    stage = skb_pkg::PH_TYPE_DATA;
                end
                skb_pkg::PH_A_LEN: begin
                    if (kind == skb_pkg::KT_RSA) begin
                        check_mpint_len(n);
                    end else if (n != skb_pkg::ED_KEY_LEN) begin
                        err = skb_pkg::ERR_RANGE;
                    end
                    first_zero = 1'b0;
                    stage      = skb_pkg::PH_A_DATA;
                end
                default: begin
                    check_mpint_len(n);
                    first_zero = 1'b0;
                    stage      = skb_pkg::PH_B_DATA;
                end
            endcase
        endfunction

        function void payload_byte(logic [7:0] b);
            logic [31:0] idx;
            idx = flen - left;
            if (stage == skb_pkg::PH_TYPE_DATA) begin
                if (flags[0] &&
                        !(idx < 32'(skb_pkg::RSA_NAME_LEN) && rsa_txt[int'(idx)] == b)) begin
                    flags[0] = 1'b0;
                end
                if (flags[1] &&
                        !(idx < 32'(skb_pkg::ED_NAME_LEN) && ed_txt[int'(idx)] == b)) begin
                    flags[1] = 1'b0;
                end
                if (flags == 2'b00) begin
                    err = skb_pkg::ERR_TYPE;
                    return;
                end
            end else if (kind == skb_pkg::KT_RSA) begin
                if (idx == 0) begin
                    if (b[7]) begin
                        err = skb_pkg::ERR_FORM;
                        return;
                    end
                    first_zero = (b == 8'h00);
                end else if (idx == 1 && first_zero && !b[7]) begin
                    err = skb_pkg::ERR_FORM;
                    return;
                end
            end
            left = left - 1;
            if (left != 0) begin
                return;
            end
            flen = '0;
            case (stage)
                skb_pkg::PH_TYPE_DATA: stage = skb_pkg::PH_A_LEN;
                skb_pkg::PH_A_DATA: begin
                    stage = (kind == skb_pkg::KT_RSA) ? skb_pkg::PH_B_LEN : skb_pkg::PH_DONE;
                end
                default: stage = skb_pkg::PH_DONE;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic lst);
            verdict_t w;
            if (seen < skb_pkg::MIN_BLOB_LEN) begin
                seen = seen + 1;
            end
            if (err == skb_pkg::ERR_NONE) begin
                case (stage)
                    skb_pkg::PH_TYPE_LEN, skb_pkg::PH_A_LEN, skb_pkg::PH_B_LEN: begin
                        length_byte(b);
                    end
                    skb_pkg::PH_TYPE_DATA, skb_pkg::PH_A_DATA, skb_pkg::PH_B_DATA: begin
                        payload_byte(b);
                    end
                    default: err = skb_pkg::ERR_TRAILING;
                endcase
            end
            if (!lst) begin
                return;
            end
            if (seen < skb_pkg::MIN_BLOB_LEN) begin
                w.err = skb_pkg::ERR_TRUNC;
            end else if (err != skb_pkg::ERR_NONE) begin
                w.err = err;
            end else if (stage != skb_pkg::PH_DONE) begin
                w.err = skb_pkg::ERR_TRUNC;
            end else begin
                w.err = skb_pkg::ERR_NONE;
            end
            w.ok   = (w.err == skb_pkg::ERR_NONE);
            w.kind = w.ok ? kind : skb_pkg::KT_UNKNOWN;
            expected_q.push_back(w);
            noted++;
            code_count[w.err]++;
            if (w.ok && w.kind == skb_pkg::KT_RSA) begin
                rsa_ok++;
            end
            if (w.ok && w.kind == skb_pkg::KT_ED) begin
                ed_ok++;
            end
            restart();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_verdict(logic vr, logic [1:0] kt, logic [2:0] ec);
            verdict_t w;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected verdict valid=%0d type=%0d code=%0d", vr, kt, ec));
                return;
            end
            w = expected_q.pop_front();
            checked++;
            if (vr !== w.ok) begin
                report($sformatf("verdict %0d: valid_res %0b, want %0b", checked, vr, w.ok));
            end
            if (kt !== w.kind) begin
                report($sformatf("verdict %0d: key_type %0d, want %0d", checked, kt, w.kind));
            end
            if (ec !== w.err) begin
                report($sformatf("verdict %0d: error_code %0d, want %0d", checked, ec, w.err));
            end
        endtask

    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    skb_cfg_if  cfg_ch ();
    skb_byte_if blob_ch ();
    skb_res_if  res_ch ();

    ssh_key_blob_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_blob  (blob_ch),
        .o_res   (res_ch)
    );

    blob_verdict_sb sb;
    bit             gaps_on = 1'b1;
    int unsigned    bytes_sent;
    int unsigned    settings_used = 1;
    int unsigned    idle_run;
    logic [7:0]     blob_q[$];

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_verdict(res_ch.valid_res, res_ch.key_type, res_ch.error_code);
        end
        res_ch.ready <= !gaps_on || ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (blob_ch.valid && blob_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_run <= 0;
        end else if (idle_run >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d verdicts outstanding.",
                     idle_run, sb.pending());
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    function automatic void put_u32(logic [31:0] v);
        blob_q.push_back(v[31:24]);
        blob_q.push_back(v[23:16]);
        blob_q.push_back(v[15:8]);
        blob_q.push_back(v[7:0]);
    endfunction

    function automatic void put_rep(int unsigned cnt, logic [7:0] v);
        repeat (cnt) blob_q.push_back(v);
    endfunction

    function automatic void put_text(string s);
        put_u32(32'(s.len()));
        for (int i = 0; i < s.len(); i++) begin
            blob_q.push_back(s[i]);
        end
    endfunction

    function automatic void put_rsa_keys();
        put_u32(1);
        blob_q.push_back(8'h01);
        put_u32(1);
        blob_q.push_back(8'h7F);
    endfunction

    function automatic void put_good_ed();
        put_text("ssh-ed25519");
        put_u32(skb_pkg::ED_KEY_LEN);
        put_rep(16, 8'h00);
        put_rep(16, 8'hFF);
    endfunction

    function automatic void put_mpint_body(int unsigned cnt, bit good);
        int unsigned start;
        start = blob_q.size();
        if (cnt == 0) begin
            return;
        end
        if (good) begin
            if (cnt >= 2 && $urandom_range(3) == 0) begin
                blob_q.push_back(8'h00);
                blob_q.push_back(8'($urandom_range(128, 255)));
            end else if (cnt == 1 && $urandom_range(3) == 0) begin
                blob_q.push_back(8'h00);
            end else begin
                blob_q.push_back(8'($urandom_range(1, 127)));
            end
        end else if (cnt >= 2 && $urandom_range(1) == 1) begin
            blob_q.push_back(8'h00);
            blob_q.push_back(8'($urandom_range(0, 127)));
        end else begin
            blob_q.push_back(8'($urandom_range(128, 255)));
        end
        while (blob_q.size() - start < cnt) begin
            blob_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    function automatic logic [31:0] pick_mpint_len();
        int unsigned r;
        int unsigned top;
        r   = $urandom_range(99);
        top = (sb.max_len == 0) ? 1 : ((sb.max_len < 12) ? sb.max_len : 12);
        if (r < 6) begin
            return 0;
        end else if (r < 12) begin
            return {16'd0, sb.max_len} + 1;
        end else if (r < 16) begin
            return {16'd0, sb.max_len};
        end else if (r < 18) begin
            return '1;
        end
        return $urandom_range(1, top);
    endfunction

    function automatic void build_random_blob();
        int unsigned kind;
        int unsigned r;
        logic [31:0] n;
        kind = $urandom_range(99);
        if (kind < 12) begin
            if ($urandom_range(1) == 1) begin
                put_u32(($urandom_range(1) == 1) ? 32'(skb_pkg::RSA_NAME_LEN)
                                                 : 32'(skb_pkg::ED_NAME_LEN));
            end
            repeat ($urandom_range(1, 20)) blob_q.push_back(8'($urandom_range(255)));
        end else if (kind < 60) begin
            case ($urandom_range(19))
                0:       put_text("ssh-rsb");
                1:       put_text("ssh-ed2");
                2:       put_text("ssh-rs");
                default: put_text("ssh-rsa");
            endcase
            repeat (2) begin
                n = pick_mpint_len();
                put_u32(n);
                put_mpint_body((n <= 32) ? n : $urandom_range(0, 8), $urandom_range(9) != 0);
            end
        end else begin
            case ($urandom_range(19))
                0:       put_text("ssh-ed25518");
                1:       put_text("ssh-rsa0000");
                default: put_text("ssh-ed25519");
            endcase
            case ($urandom_range(15))
                0:       n = 0;
                1:       n = skb_pkg::ED_KEY_LEN - 1;
                2:       n = skb_pkg::ED_KEY_LEN + 1;
                3:       n = $urandom();
                default: n = skb_pkg::ED_KEY_LEN;
            endcase
            put_u32(n);
            repeat ((n <= 40) ? n : 8) blob_q.push_back(8'($urandom_range(255)));
        end
        r = $urandom_range(99);
        if (r < 10 && blob_q.size() > 1) begin
            blob_q = blob_q[0:$urandom_range(0, blob_q.size() - 2)];
        end else if (r < 18) begin
            repeat ($urandom_range(1, 3)) blob_q.push_back(8'($urandom_range(255)));
        end else if (r < 24) begin
            blob_q[$urandom_range(blob_q.size() - 1)] = 8'($urandom_range(255));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (gaps_on && $urandom_range(99) < 13) begin
            blob_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        blob_ch.valid     <= 1'b1;
        blob_ch.data_byte <= b;
        blob_ch.last_byte <= lst;
        @(posedge i_clk);
        while (!blob_ch.ready) @(posedge i_clk);
        sb.note_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic send_blob();
        foreach (blob_q[i]) begin
            send_byte(blob_q[i], i == blob_q.size() - 1);
        end
        blob_q.delete();
    endtask

    task automatic drain();
        blob_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_max(input logic [15:0] v);
        drain();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.max_mpint_bytes <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        sb.set_max(v);
        settings_used++;
    endtask

    task automatic run_directed();
        put_text("ssh-rsa"); put_rsa_keys(); send_blob();
        put_text("ssh-rsa"); put_u32(2); put_rep(1, 8'h00); put_rep(1, 8'h80);
        put_u32(1); put_rep(1, 8'h00); send_blob();
        put_good_ed(); send_blob();
        put_u32(32'(skb_pkg::RSA_NAME_LEN)); put_rep(3, 8'h73); send_blob();
        put_rep(1, 8'hFF); send_blob();
        put_u32(5); put_rep(2, 8'h41); send_blob();
        put_text("ssh-rsax"); put_rep(8, 8'h00); send_blob();
        put_u32('1); put_rep(4, 8'h73); send_blob();
        put_text("ssh-rsb"); put_rsa_keys(); send_blob();
        put_text("ssh-ed2"); put_rsa_keys(); send_blob();
        put_text("ssh-rsa"); put_u32(1); put_rep(1, 8'h80); put_rsa_keys(); send_blob();
        put_text("ssh-rsa"); put_u32(1); put_rep(1, 8'h01); put_u32(2); put_rep(1, 8'h00);
        put_rep(1, 8'h7F); send_blob();
        put_text("ssh-rsa"); put_u32(0); put_rsa_keys(); send_blob();
        put_text("ssh-rsa"); put_u32(skb_pkg::MAX_MPINT_RST + 1);
        put_rep(4, 8'h11); send_blob();
        put_text("ssh-rsa"); put_u32(skb_pkg::MAX_MPINT_RST);
        put_rep(4, 8'h11); send_blob();
        put_text("ssh-rsa"); put_u32(1); put_rep(1, 8'h01); put_u32('1); put_rep(1, 8'h01);
        send_blob();
        put_text("ssh-ed25519"); put_u32(skb_pkg::ED_KEY_LEN - 1); put_rep(31, 8'h22);
        send_blob();
        put_text("ssh-ed25519"); put_u32(skb_pkg::ED_KEY_LEN + 1); put_rep(33, 8'h22);
        send_blob();
        put_text("ssh-rsa"); put_rsa_keys(); put_rep(1, 8'h00); send_blob();
        put_good_ed(); put_rep(2, 8'hFF); send_blob();
        put_text("ssh-rsa"); put_u32(1); put_rep(1, 8'h01); put_rep(2, 8'h00); send_blob();
        put_text("ssh-ed25519"); put_u32(skb_pkg::ED_KEY_LEN); put_rep(10, 8'h33);
        send_blob();
    endtask

    initial begin
        logic [15:0] max_plan[5];
        int unsigned phase_start;
        bit          paused;
        sb                     = new();
        paused                 = 1'b0;
        blob_ch.valid          = 1'b0;
        blob_ch.data_byte      = 8'h00;
        blob_ch.last_byte      = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.max_mpint_bytes = 16'd0;
        res_ch.ready           = 1'b0;
        max_plan = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom_range(2, 12)),
                     skb_pkg::MAX_MPINT_RST};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                write_max(max_plan[p - 1]);
            end
            gaps_on     <= (p != 3);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES || (p == 5 && sb.noted < 80)) begin
                if (p == 4 && !paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
                    drain();
                    paused = 1'b1;
                end
                build_random_blob();
                send_blob();
            end
        end

        drain();
        $display("Sent %0d blob bytes as %0d blobs under %0d max mpint settings %s",
                 bytes_sent, sb.noted, settings_used, "(0 and 65535 too).");
        $display("Verdicts: %0d rsa ok, %0d ed25519 ok; codes 1..5: %0d %0d %0d %0d %0d.",
                 sb.rsa_ok, sb.ed_ok, sb.code_count[skb_pkg::ERR_TRUNC],
                 sb.code_count[skb_pkg::ERR_TYPE], sb.code_count[skb_pkg::ERR_FORM],
                 sb.code_count[skb_pkg::ERR_RANGE], sb.code_count[skb_pkg::ERR_TRAILING]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
